// File: rtl/core/adc_sample_averager_with_supply_calc_top_defines.svh
// assertion macros shared by the averager rtl
// no dependencies; expects clk and rst in the scope of use
`ifndef ADC_SAMPLE_AVERAGER_WITH_SUPPLY_CALC_TOP_DEFINES_SVH
`define ADC_SAMPLE_AVERAGER_WITH_SUPPLY_CALC_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ASV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/asv_pkg.sv
// types and constants for the sample averager
// no dependencies
package asv_pkg;

  localparam int VALUE_W  = 16;
  localparam int SUPPLY_W = 21;
  localparam int COUNT_W  = 8;

  localparam logic [SUPPLY_W-1:0] SUPPLY_CONST = 21'd1125300;
  localparam logic [VALUE_W-1:0]  VALUE_MAX    = 16'hFFFF;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_COUNT    = 2'd1;
  localparam logic [1:0] ERR_ZERO_AVG = 2'd2;
  localparam logic [1:0] ERR_OVF      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AVG,
    S_MV,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/asv_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on asv_pkg and the defines header
`include "adc_sample_averager_with_supply_calc_top_defines.svh"

module asv_div import asv_pkg::*; #(
  parameter int DDW = 21,
  parameter int DVW = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic [DDW-1:0] quotient,
  output div_stat_t      stat
);

  localparam int CNT_W = $clog2(DDW);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVW-1:0]   rem;
  logic [DDW-1:0]   quo;
  logic [DVW-1:0]   dvs;

  logic [DVW:0] trial;
  logic [DVW:0] diff;
  logic         ge;

  assign trial = {rem, quo[DDW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = ~diff[DVW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DDW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      quo <= {quo[DDW-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `ASV_ASSERT_NXT(a_done_pulse, done, !done, "divider done held longer than one cycle")
  `ASV_ASSERT_IMP(a_no_restart, start, !busy, "divider restarted while busy")
  `ASV_ASSERT_IMP(a_done_idle, done, !busy, "divider done while still busy")

endmodule

// File: rtl/core/adc_sample_averager_with_supply_calc_top.sv
// converter sample averager with bandgap supply calculation, top level
// depends on asv_pkg, asv_div and the defines header
`include "adc_sample_averager_with_supply_calc_top_defines.svh"

// usage
//  input channel: sample, channel, mode under in_valid / in_stall; an item is taken
//  when in_valid is high and in_stall low. config channel: sample_count under
//  cfg_valid / cfg_ready, written while the block is idle.
//  every accepted item is summed; the item that completes a batch of sample_count
//  samples produces one result (value, channel_out, mode_out, error) on the output
//  channel under out_valid / out_stall. with sample_count zero each item gives a
//  result of value 0 and error 1.
//  timing: an item that does not close a batch is taken without a stall. a closing
//  item runs the shared restoring divider, one quotient bit a cycle over
//  max(SAMPLE_BITS+8, 21) bits (21 at the default width), and in_stall stays high
//  until its result is pushed. plain mode pushes after the first division; supply
//  mode, unless the average is zero, runs the divider again for 1125300 / average
//  first. a zero-count item goes straight to the push, without the divider.
//  a result waits in the output register while out_stall is high; the next item
//  is still taken and summed, and only a closing item waits until it leaves.
//  synchronous reset clears the running sum and count, sets sample_count to 1
//  and empties the output register.
module adc_sample_averager_with_supply_calc_top import asv_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [2:0]             channel,
  input  logic                   mode,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_W-1:0]     sample_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_W-1:0]     value,
  output logic [2:0]             channel_out,
  output logic                   mode_out,
  output logic [1:0]             error
);

  localparam int SUM_BITS = SAMPLE_BITS + 8;
  localparam int DIV_W    = (SUM_BITS > SUPPLY_W) ? SUM_BITS : SUPPLY_W;

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0]  batch_len;
  logic [SUM_BITS-1:0] sum_acc;
  logic [COUNT_W-1:0]  taken;

  // staged result, waits here until the output register is free
  logic [VALUE_W-1:0] res_value;
  logic [1:0]         res_error;
  logic [2:0]         res_channel;
  logic               res_mode;

  // input side
  logic                in_acc;
  logic [SUM_BITS-1:0] sum_new;
  logic [COUNT_W:0]    n_next;
  logic                zero_count;
  logic                batch_done;

  // shared divider
  logic                   div_start;
  logic [DIV_W-1:0]       div_a;
  logic [SAMPLE_BITS-1:0] div_b;
  logic [DIV_W-1:0]       div_q;
  div_stat_t              div_st;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   avg_zero;
  logic                   mv_ovf;

  logic push;

  // checker helpers
  logic in_div;
  logic err_plain;
  logic err_sat;

  assign in_acc     = in_valid && !in_stall;
  assign sum_new    = sum_acc + SUM_BITS'(sample);
  assign n_next     = {1'b0, taken} + (COUNT_W + 1)'(1);
  assign zero_count = (batch_len == '0);
  assign batch_done = !(n_next < {1'b0, batch_len});

  // quotient of the first pass is the average; upper bits are zero by range
  assign avg      = div_q[SAMPLE_BITS-1:0];
  assign avg_zero = (avg == '0);
  assign mv_ovf   = |div_q[DIV_W-1:VALUE_W];

  // operands: batch sum / count from idle, supply constant / average after that
  always_comb begin
    if (state == S_IDLE) begin
      div_a = DIV_W'(sum_new);
      div_b = SAMPLE_BITS'(n_next[COUNT_W-1:0]);
    end else begin
      div_a = DIV_W'(SUPPLY_CONST);
      div_b = avg;
    end
  end

  asv_div #(
    .DDW (DIV_W),
    .DVW (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .stat     (div_st)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (zero_count) begin
            state_next = S_PUSH;
          end else if (batch_done) begin
            state_next = S_AVG;
          end
        end
      end
      S_AVG: begin
        if (div_st.done) begin
          if (res_mode && !avg_zero) begin
            state_next = S_MV;
          end else begin
            state_next = S_PUSH;
          end
        end
      end
      S_MV: begin
        if (div_st.done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    cfg_ready = (state == S_IDLE);
    div_start = 1'b0;
    push      = 1'b0;
    unique case (state)
      S_IDLE: div_start = in_acc && !zero_count && batch_done;
      S_AVG:  div_start = div_st.done && res_mode && !avg_zero;
      S_MV:   div_start = 1'b0;
      S_PUSH: push      = !out_valid || !out_stall;
      default: begin
        div_start = 1'b0;
        push      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and batch accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_len <= COUNT_W'(1);
      sum_acc   <= '0;
      taken     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        batch_len <= sample_count;
      end
      if (in_acc) begin
        if (zero_count || batch_done) begin
          sum_acc <= '0;
          taken   <= '0;
        end else begin
          sum_acc <= sum_new;
          taken   <= n_next[COUNT_W-1:0];
        end
      end
    end
  end

  // staged result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_channel <= channel;
      res_mode    <= mode;
      res_value   <= '0;
      res_error   <= ERR_COUNT;
    end else if (state == S_AVG && div_st.done) begin
      if (!res_mode) begin
        res_value <= VALUE_W'(avg);
        res_error <= ERR_OK;
      end else if (avg_zero) begin
        res_value <= VALUE_MAX;
        res_error <= ERR_ZERO_AVG;
      end
    end else if (state == S_MV && div_st.done) begin
      if (mv_ovf) begin
        res_value <= VALUE_MAX;
        res_error <= ERR_OVF;
      end else begin
        res_value <= div_q[VALUE_W-1:0];
        res_error <= ERR_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      value       <= res_value;
      channel_out <= res_channel;
      mode_out    <= res_mode;
      error       <= res_error;
    end
  end

  assign in_div    = (state == S_AVG) || (state == S_MV);
  assign err_plain = (error == ERR_OK) || (error == ERR_COUNT);
  assign err_sat   = (error == ERR_ZERO_AVG) || (error == ERR_OVF);

  `ASV_ASSERT_IMP(a_acc_div_idle, in_acc, !div_st.busy, "item taken while divider busy")
  `ASV_ASSERT_IMP(a_done_state, div_st.done, in_div, "divider done outside a compute state")
  `ASV_ASSERT_IMP(a_plain_err, out_valid && !mode_out, err_plain, "supply error on plain result")
  `ASV_ASSERT_IMP(a_sat_value, out_valid && err_sat, value == VALUE_MAX, "flagged result not saturated")

endmodule
